>>> rtl/irpfg_pkg.sv
`timescale 1ns / 1ps

package irpfg_pkg;

   localparam int DUR_W  = 17;
   localparam int POS_W  = 7;
   localparam int PROT_W = 3;

   // Protocol codes held in the protocol register.
   localparam logic [PROT_W-1:0] PROTO_NEC  = 3'd0;
   localparam logic [PROT_W-1:0] PROTO_RC5  = 3'd1;
   localparam logic [PROT_W-1:0] PROTO_RC6  = 3'd2;
   localparam logic [PROT_W-1:0] PROTO_JVC  = 3'd3;
   localparam logic [PROT_W-1:0] PROTO_SIRC = 3'd4;
   localparam logic [PROT_W-1:0] PROTO_ITT  = 3'd5;

   // Register indexes on the configuration port.
   localparam logic CSR_PROTOCOL = 1'b0;
   localparam logic CSR_ADDRESS  = 1'b1;

   // Input word kinds.
   localparam logic KIND_PRESS = 1'b0;
   localparam logic KIND_PULL  = 1'b1;

   // Frame lengths in pulses.
   localparam logic [POS_W-1:0] LEN_NEC  = 7'd68;
   localparam logic [POS_W-1:0] LEN_RC5  = 7'd59;
   localparam logic [POS_W-1:0] LEN_RC6  = 7'd45;
   localparam logic [POS_W-1:0] LEN_JVC  = 7'd101;
   localparam logic [POS_W-1:0] LEN_SIRC = 7'd26;
   localparam logic [POS_W-1:0] LEN_ITT  = 7'd26;

   // Pulse durations in microseconds.
   localparam logic [DUR_W-1:0] D_NEC_HDR_MARK  = 17'd9000;
   localparam logic [DUR_W-1:0] D_NEC_HDR_SPACE = 17'd4500;
   localparam logic [DUR_W-1:0] D_NEC_MARK      = 17'd562;
   localparam logic [DUR_W-1:0] D_NEC_ONE       = 17'd1688;
   localparam logic [DUR_W-1:0] D_NEC_ZERO      = 17'd563;
   localparam logic [DUR_W-1:0] D_NEC_TAIL      = 17'd40000;
   localparam logic [DUR_W-1:0] D_RC5_HALF      = 17'd889;
   localparam logic [DUR_W-1:0] D_RC5_GAP_BASE  = 17'd114000;
   localparam logic [DUR_W-1:0] D_RC6_LEADER    = 17'd2666;
   localparam logic [DUR_W-1:0] D_RC6_TRAILER   = 17'd889;
   localparam logic [DUR_W-1:0] D_RC6_HALF      = 17'd444;
   localparam logic [DUR_W-1:0] D_JVC_HDR_MARK  = 17'd8400;
   localparam logic [DUR_W-1:0] D_JVC_HDR_SPACE = 17'd4200;
   localparam logic [DUR_W-1:0] D_JVC_MARK      = 17'd562;
   localparam logic [DUR_W-1:0] D_JVC_ONE       = 17'd1574;
   localparam logic [DUR_W-1:0] D_JVC_ZERO      = 17'd524;
   localparam logic [DUR_W-1:0] D_JVC_GAP_BASE  = 17'd60000;
   localparam logic [DUR_W-1:0] D_SIRC_HDR      = 17'd2400;
   localparam logic [DUR_W-1:0] D_SIRC_ONE      = 17'd1200;
   localparam logic [DUR_W-1:0] D_SIRC_UNIT     = 17'd600;
   localparam logic [DUR_W-1:0] D_ITT_MARK      = 17'd10;
   localparam logic [DUR_W-1:0] D_ITT_LEAD      = 17'd290;
   localparam logic [DUR_W-1:0] D_ITT_ONE       = 17'd190;
   localparam logic [DUR_W-1:0] D_ITT_ZERO      = 17'd90;

   // Start bits of RC5 and the header levels of RC6, bit i for pulse i.
   localparam logic [5:0]  RC5_START_LV = 6'b011010;
   localparam logic [11:0] RC6_HEAD_LV  = 12'b1010_1010_0101;

   typedef struct packed {
      logic             level;
      logic [DUR_W-1:0] dur;
   } pulse_type;

endpackage

>>> rtl/ir_remote_pulse_frame_generator_core.sv
`timescale 1ns / 1ps

// Infrared remote pulse frame generator for NEC, RC5, RC6 mode 0, JVC, SIRC and ITT
// framing. A press word (tuser 0) latches the command byte in tdata together with the
// protocol and device address registers and restarts the frame; it returns no word.
// Each pull word (tuser 1) returns one word: the next pulse's level in bit 0 and its
// duration in microseconds in bits 17:1, with tlast on the final pulse, or an empty
// word (tuser 1, data zero) when no pulse is pending. Each pulse is formed from the
// pulse counter and small per-protocol templates in one pass between the frame state
// and a single output register, so a pull's result appears in the cycle after the pull
// is taken. A new word is taken in any cycle in which the output register is empty or
// its word is being taken, so with the result side ready one word moves every cycle;
// a stalled result holds back the input, presses included. The RC5 and JVC gaps are
// computed from the time already sent in the frame. Register writes affect the next
// press only.
module ir_remote_pulse_frame_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] code
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] level, [17:1] duration_us, [23:18] zero
   output logic        rsp_tuser,   // [0] empty_res
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   import irpfg_pkg::*;

   logic [PROT_W-1:0] protocol_ff, protocol_in;
   logic [7:0]        address_ff, address_in;
   logic [PROT_W-1:0] held_proto_ff, held_proto_in;
   logic [7:0]        held_addr_ff, held_addr_in;
   logic [7:0]        held_code_ff, held_code_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              active_ff, active_in;
   logic [DUR_W-1:0]  elapsed_ff, elapsed_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_last_ff, rsp_last_in;
   pulse_type         rsp_pulse_ff, rsp_pulse_in;

   logic              req_acc;
   logic [POS_W-1:0]  cur_len;
   logic [POS_W-1:0]  pos_next;
   pulse_type         cur_pulse;

   function automatic pulse_type mk(input logic lv, input logic [DUR_W-1:0] du);
      pulse_type r;
      r.level = lv;
      r.dur   = du;
      return r;
   endfunction

   // Bit of a field sent MSB first; x counts half-bit pulses from the field start.
   function automatic logic fbit(input logic [7:0] v, input logic [2:0] top,
                                 input logic [POS_W-1:0] x);
      logic [2:0] idx;
      idx = top - x[3:1];
      return v[idx];
   endfunction

   // Manchester half-bit: a one is space then mark, a zero is mark then space.
   function automatic pulse_type manch(input logic b, input logic [POS_W-1:0] x,
                                       input logic [DUR_W-1:0] du);
      return mk(x[0] ? b : ~b, du);
   endfunction

   function automatic logic [POS_W-1:0] frame_len(input logic [PROT_W-1:0] p);
      logic [POS_W-1:0] n;
      unique case (p)
         PROTO_NEC:  n = LEN_NEC;
         PROTO_RC5:  n = LEN_RC5;
         PROTO_RC6:  n = LEN_RC6;
         PROTO_JVC:  n = LEN_JVC;
         PROTO_SIRC: n = LEN_SIRC;
         PROTO_ITT:  n = LEN_ITT;
         default:    n = '0;
      endcase
      return n;
   endfunction

   function automatic pulse_type pulse_at(input logic [PROT_W-1:0] p,
                                          input logic [POS_W-1:0] pos,
                                          input logic [7:0] a, input logic [7:0] c,
                                          input logic [DUR_W-1:0] el);
      pulse_type        r;
      logic [POS_W-1:0] q;
      logic [7:0]       v;
      logic             b;
      r = mk(1'b0, '0);
      q = '0;
      v = '0;
      b = 1'b0;
      unique case (p)
         PROTO_NEC: begin
            q = pos - 7'd2;
            unique case (q[5:4])
               2'd0:    v = a;
               2'd1:    v = ~a;
               2'd2:    v = c;
               default: v = ~c;
            endcase
            b = fbit(v, 3'd7, q);
            priority if (pos == 7'd0)  r = mk(1'b1, D_NEC_HDR_MARK);
            else if (pos == 7'd1)      r = mk(1'b0, D_NEC_HDR_SPACE);
            else if (pos == 7'd66)     r = mk(1'b1, D_NEC_MARK);
            else if (pos == 7'd67)     r = mk(1'b0, D_NEC_TAIL);
            else if (!q[0])            r = mk(1'b1, D_NEC_MARK);
            else                       r = mk(1'b0, b ? D_NEC_ONE : D_NEC_ZERO);
         end
         PROTO_RC5: begin
            // The repeat frame follows the gap and sends six command bits.
            q = (pos > 7'd30) ? pos - 7'd31 : pos;
            priority if (pos == 7'd30) r = mk(1'b0, D_RC5_GAP_BASE - el);
            else if (q < 7'd6)         r = mk(RC5_START_LV[q[2:0]], D_RC5_HALF);
            else if (q < 7'd16)
               r = manch(fbit(a, 3'd4, q - 7'd6), q - 7'd6, D_RC5_HALF);
            else if (pos < 7'd30)
               r = manch(fbit(c, 3'd6, q - 7'd16), q - 7'd16, D_RC5_HALF);
            else
               r = manch(fbit(c, 3'd5, q - 7'd16), q - 7'd16, D_RC5_HALF);
         end
         PROTO_RC6: begin
            priority if (pos < 7'd12) begin
               if (pos == 7'd0)
                  r = mk(RC6_HEAD_LV[pos[3:0]], D_RC6_LEADER);
               else if (pos == 7'd1 || pos == 7'd10 || pos == 7'd11)
                  r = mk(RC6_HEAD_LV[pos[3:0]], D_RC6_TRAILER);
               else
                  r = mk(RC6_HEAD_LV[pos[3:0]], D_RC6_HALF);
            end else if (pos < 7'd28)
               r = manch(fbit(a, 3'd7, pos - 7'd12), pos - 7'd12, D_RC6_HALF);
            else if (pos < 7'd44)
               r = manch(fbit(c, 3'd7, pos - 7'd28), pos - 7'd28, D_RC6_HALF);
            else
               r = mk(1'b0, D_RC6_LEADER);
         end
         PROTO_JVC: begin
            // Headed frame, gap, headerless repeat, then a headed frame again.
            priority if (pos < 7'd34) q = pos - 7'd2;
            else if (pos < 7'd67)     q = pos - 7'd35;
            else                      q = {2'b00, 5'(pos - 7'd69)};
            v = (q < 7'd16) ? a : c;
            b = fbit(v, 3'd7, q);
            priority if (pos == 7'd0 || pos == 7'd67)  r = mk(1'b1, D_JVC_HDR_MARK);
            else if (pos == 7'd1 || pos == 7'd68)      r = mk(1'b0, D_JVC_HDR_SPACE);
            else if (pos == 7'd34)                     r = mk(1'b0, D_JVC_GAP_BASE - el);
            else if (!q[0])                            r = mk(1'b1, D_JVC_MARK);
            else                                       r = mk(1'b0, b ? D_JVC_ONE : D_JVC_ZERO);
         end
         PROTO_SIRC: begin
            b = (pos < 7'd16) ? fbit(c, 3'd6, pos - 7'd2) : fbit(a, 3'd4, pos - 7'd16);
            priority if (pos == 7'd0) r = mk(1'b1, D_SIRC_HDR);
            else if (pos == 7'd1)     r = mk(1'b0, D_SIRC_UNIT);
            else if (!pos[0])         r = mk(1'b1, b ? D_SIRC_ONE : D_SIRC_UNIT);
            else                      r = mk(1'b0, D_SIRC_UNIT);
         end
         default: begin
            b = (pos < 7'd10) ? fbit(a, 3'd3, pos - 7'd2) : fbit(c, 3'd5, pos - 7'd10);
            priority if (pos == 7'd0 || pos == 7'd22 || pos == 7'd24)
               r = mk(1'b1, D_ITT_MARK);
            else if (pos == 7'd1 || pos == 7'd23) r = mk(1'b0, D_ITT_LEAD);
            else if (pos == 7'd25)                r = mk(1'b0, D_ITT_ZERO);
            else if (!pos[0])                     r = mk(1'b1, D_ITT_MARK);
            else                                  r = mk(1'b0, b ? D_ITT_ONE : D_ITT_ZERO);
         end
      endcase
      return r;
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign cur_len   = frame_len(held_proto_ff);
   assign pos_next  = pos_ff + 7'd1;
   assign cur_pulse = pulse_at(held_proto_ff, pos_ff, held_addr_ff, held_code_ff, elapsed_ff);

   always_comb begin
      protocol_in   = protocol_ff;
      address_in    = address_ff;
      held_proto_in = held_proto_ff;
      held_addr_in  = held_addr_ff;
      held_code_in  = held_code_ff;
      pos_in        = pos_ff;
      active_in     = active_ff;
      elapsed_in    = elapsed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_pulse_in  = rsp_pulse_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PROTOCOL: protocol_in = csr_data[PROT_W-1:0];
            default:      address_in  = csr_data;
         endcase
      end

      if (req_acc) begin
         if (req_tuser == KIND_PRESS) begin
            held_code_in  = req_tdata;
            held_proto_in = protocol_ff;
            held_addr_in  = address_ff;
            pos_in        = '0;
            elapsed_in    = '0;
            active_in     = frame_len(protocol_ff) != '0;
         end else begin
            rsp_valid_in = 1'b1;
            if (!active_ff || pos_ff >= cur_len) begin
               active_in    = 1'b0;
               rsp_empty_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_pulse_in = mk(1'b0, '0);
            end else begin
               elapsed_in   = elapsed_ff + cur_pulse.dur;
               pos_in       = pos_next;
               rsp_empty_in = 1'b0;
               rsp_pulse_in = cur_pulse;
               rsp_last_in  = pos_next >= cur_len;
               if (pos_next >= cur_len) begin
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff   <= PROTO_JVC;
         address_ff    <= 8'd3;
         held_proto_ff <= PROTO_JVC;
         held_addr_ff  <= 8'd3;
         held_code_ff  <= '0;
         pos_ff        <= '0;
         active_ff     <= 1'b0;
         elapsed_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         protocol_ff   <= protocol_in;
         address_ff    <= address_in;
         held_proto_ff <= held_proto_in;
         held_addr_ff  <= held_addr_in;
         held_code_ff  <= held_code_in;
         pos_ff        <= pos_in;
         active_ff     <= active_in;
         elapsed_ff    <= elapsed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_pulse_ff <= rsp_pulse_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_pulse_ff.dur, rsp_pulse_ff.level};

`ifndef ASSERT_OFF
   // A running frame never points past its own end.
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> pos_ff < cur_len)
      else $error("active frame beyond its length");

   // An empty word carries no pulse and never closes a frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0 && !rsp_tlast))
      else $error("empty word with pulse data");

   // A press restarts the frame from the first pulse.
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == KIND_PRESS) |=> (pos_ff == '0 && elapsed_ff == '0))
      else $error("press did not restart the frame");

   // The final pulse of a frame leaves the generator idle.
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == KIND_PULL && active_ff && pos_next >= cur_len)
      |=> (!active_ff && rsp_tlast))
      else $error("frame still active after last pulse");
`endif

endmodule

>>> test/tb_ir_remote_pulse_frame_generator_core.sv
`timescale 1ns / 1ps

module tb_ir_remote_pulse_frame_generator_core;
   import irpfg_pkg::*;

   // Protocol codes that select no framing.
   localparam logic [PROT_W-1:0] PROTO_NONE_A = 3'd6;
   localparam logic [PROT_W-1:0] PROTO_NONE_B = 3'd7;

   localparam int TOTAL_WORDS   = 1950;
   localparam int QUIET_TAIL    = 250;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;
   localparam int STALL_LIMIT   = 3000;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      bit               empty;
      bit               level;
      logic [DUR_W-1:0] dur;
      bit               last;
   } ir_word_type;

   class pulse_frame_board;
      logic [PROT_W-1:0] protocol_reg;
      logic [7:0]        address_reg;
      logic [PROT_W-1:0] proto_held;
      logic [7:0]        addr_held;
      logic [7:0]        code_held;
      int                position;
      bit                active;
      logic [DUR_W-1:0]  elapsed;
      ir_word_type       pulse_fifo[$];
      int                mismatches;
      int                words_checked;
      int                empty_words;
      int                frame_ends;
      int                presses;
      logic [7:0]        proto_seen;

      function new();
         protocol_reg = PROTO_JVC;
         address_reg  = 8'd3;
         proto_held   = PROTO_JVC;
         addr_held    = 8'd3;
         code_held    = 8'd0;
         position     = 0;
         active       = 1'b0;
         elapsed      = '0;
         mismatches   = 0;
         words_checked = 0;
         empty_words  = 0;
         frame_ends   = 0;
         presses      = 0;
         proto_seen   = 8'd0;
      endfunction

      function int pulses_in_frame(logic [PROT_W-1:0] p);
         case (p)
            PROTO_NEC:  return 68;
            PROTO_RC5:  return 59;
            PROTO_RC6:  return 45;
            PROTO_JVC:  return 101;
            PROTO_SIRC: return 26;
            PROTO_ITT:  return 26;
            default:    return 0;
         endcase
      endfunction

      // Bit of an nbits-wide field, sent MSB first; q counts half-bit pulses.
      function bit field_bit(logic [7:0] v, int nbits, int q);
         return v[(nbits - 1 - (q >> 1)) & 7];
      endfunction

      function pulse_type mk_pulse(bit lv, int du);
         pulse_type r;
         r.level = lv;
         r.dur   = du[DUR_W-1:0];
         return r;
      endfunction

      // A one goes space then mark, a zero mark then space.
      function pulse_type half_bit(bit b, int q, int du);
         return mk_pulse(((q & 1) == 0) ? !b : b, du);
      endfunction

      function pulse_type jvc_pulse(int q, logic [7:0] a, logic [7:0] c);
         bit b;
         b = field_bit((q < 16) ? a : c, 8, q & 15);
         if ((q & 1) == 0) return mk_pulse(1'b1, 562);
         return mk_pulse(1'b0, b ? 1574 : 524);
      endfunction

      function pulse_type frame_pulse(logic [PROT_W-1:0] p, int pos, logic [7:0] a,
                                      logic [7:0] c, output bit gap, output int gap_base);
         logic [5:0]  rc5_start;
         logic [11:0] rc6_head;
         int          q;
         int          idx;
         logic [7:0]  v;
         bit          b;
         rc5_start = 6'b011010;
         rc6_head  = 12'b1010_1010_0101;
         gap = 1'b0;
         gap_base = 0;
         case (p)
            PROTO_NEC: begin
               if (pos == 0) return mk_pulse(1'b1, 9000);
               if (pos == 1) return mk_pulse(1'b0, 4500);
               if (pos == 66) return mk_pulse(1'b1, 562);
               if (pos == 67) return mk_pulse(1'b0, 40000);
               q = pos - 2;
               idx = (q >> 4) & 3;
               v = (idx == 0) ? a : (idx == 1) ? ~a : (idx == 2) ? c : ~c;
               b = field_bit(v, 8, q & 15);
               if ((q & 1) == 0) return mk_pulse(1'b1, 562);
               return mk_pulse(1'b0, b ? 1688 : 563);
            end
            PROTO_RC5: begin
               if (pos == 30) begin
                  gap = 1'b1;
                  gap_base = 114000;
                  return mk_pulse(1'b0, 0);
               end
               q = (pos > 30) ? pos - 31 : pos;
               if (q < 6) return mk_pulse(rc5_start[q], 889);
               if (q < 16) return half_bit(field_bit(a, 5, q - 6), q - 6, 889);
               // The repeat frame carries only six command bits.
               if (pos < 30) return half_bit(field_bit(c, 7, q - 16), q - 16, 889);
               return half_bit(field_bit(c, 6, q - 16), q - 16, 889);
            end
            PROTO_RC6: begin
               if (pos < 12) begin
                  if (pos == 0) return mk_pulse(rc6_head[pos], 2666);
                  if (pos == 1 || pos >= 10) return mk_pulse(rc6_head[pos], 889);
                  return mk_pulse(rc6_head[pos], 444);
               end
               if (pos < 28) return half_bit(field_bit(a, 8, pos - 12), pos - 12, 444);
               if (pos < 44) return half_bit(field_bit(c, 8, pos - 28), pos - 28, 444);
               return mk_pulse(1'b0, 2666);
            end
            PROTO_JVC: begin
               if (pos == 0 || pos == 67) return mk_pulse(1'b1, 8400);
               if (pos == 1 || pos == 68) return mk_pulse(1'b0, 4200);
               if (pos == 34) begin
                  gap = 1'b1;
                  gap_base = 60000;
                  return mk_pulse(1'b0, 0);
               end
               if (pos < 34) return jvc_pulse(pos - 2, a, c);
               if (pos < 67) return jvc_pulse(pos - 35, a, c);
               return jvc_pulse((pos - 69) & 31, a, c);
            end
            PROTO_SIRC: begin
               if (pos == 0) return mk_pulse(1'b1, 2400);
               if (pos == 1) return mk_pulse(1'b0, 600);
               b = (pos < 16) ? field_bit(c, 7, pos - 2) : field_bit(a, 5, pos - 16);
               if ((pos & 1) == 0) return mk_pulse(1'b1, b ? 1200 : 600);
               return mk_pulse(1'b0, 600);
            end
            default: begin
               if (pos == 0 || pos == 22 || pos == 24) return mk_pulse(1'b1, 10);
               if (pos == 1 || pos == 23) return mk_pulse(1'b0, 290);
               if (pos == 25) return mk_pulse(1'b0, 90);
               b = (pos < 10) ? field_bit(a, 4, pos - 2) : field_bit(c, 6, pos - 10);
               if ((pos & 1) == 0) return mk_pulse(1'b1, 10);
               return mk_pulse(1'b0, b ? 190 : 90);
            end
         endcase
      endfunction

      function void write_reg(logic idx, logic [7:0] val);
         if (idx == CSR_PROTOCOL) protocol_reg = val[PROT_W-1:0];
         else address_reg = val;
      endfunction

      function void note_word(logic kind, logic [7:0] code);
         int          len;
         pulse_type   pl;
         bit          gap;
         int          gap_base;
         ir_word_type w;
         if (kind == KIND_PRESS) begin
            code_held  = code;
            proto_held = protocol_reg;
            addr_held  = address_reg;
            position   = 0;
            elapsed    = '0;
            active     = pulses_in_frame(proto_held) > 0;
            presses++;
            proto_seen[proto_held] = 1'b1;
            return;
         end
         len = pulses_in_frame(proto_held);
         w.empty = 1'b0;
         w.last  = 1'b0;
         if (!active || position >= len) begin
            active  = 1'b0;
            w.empty = 1'b1;
            w.level = 1'b0;
            w.dur   = '0;
            pulse_fifo = {pulse_fifo, w};
            return;
         end
         pl = frame_pulse(proto_held, position, addr_held, code_held, gap, gap_base);
         // Gaps fill the frame up to a fixed period, wrapping like the counter does.
         if (gap) pl.dur = DUR_W'(gap_base - int'(elapsed));
         elapsed  = elapsed + pl.dur;
         position = (position + 1) & 127;
         if (position >= len) begin
            w.last = 1'b1;
            active = 1'b0;
         end
         w.level = pl.level;
         w.dur   = pl.dur;
         pulse_fifo = {pulse_fifo, w};
      endfunction

      function void check_word(logic empty, logic [23:0] data, logic last);
         ir_word_type exp;
         if (pulse_fifo.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("Unexpected result word: empty=%0b data=%h last=%0b",
                        empty, data, last);
            mismatches++;
            return;
         end
         exp = pulse_fifo.pop_front();
         words_checked++;
         if (exp.empty) empty_words++;
         if (exp.last) frame_ends++;
         if (empty !== exp.empty || data[0] !== exp.level || data[17:1] !== exp.dur ||
             data[23:18] !== 6'd0 || last !== exp.last) begin
            if (mismatches < MAX_REPORTS)
               $display({"Mismatch on word %0d: expected empty=%0b level=%0b dur=%0d ",
                         "last=%0b, got empty=%0b level=%0b dur=%0d last=%0b pad=%h"},
                        words_checked, exp.empty, exp.level, exp.dur, exp.last,
                        empty, data[0], data[17:1], last, data[23:18]);
            mismatches++;
         end
      endfunction

      function int pending();
         return pulse_fifo.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_data = 8'd0;

   pulse_frame_board sb = new();

   int sent_words = 0;
   int send_odds = 0;
   int rsp_odds = 0;
   int rsp_stall_left = 0;
   int quiet_cycles = 0;
   int midframe_writes = 0;

   ir_remote_pulse_frame_generator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_word(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tuser, rsp_tdata, rsp_tlast);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
      end
   end

   // Result side back-pressure in bursts.
   always @(posedge clock) begin
      if (rsp_odds == 0) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(1, rsp_odds) == 1) begin
         rsp_stall_left <= $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_word(logic kind, logic [7:0] code);
      int gap;
      // The last part of the run goes without idling on either side.
      if (sent_words >= TOTAL_WORDS - QUIET_TAIL) begin
         send_odds = 0;
         rsp_odds  = 0;
      end
      gap = (send_odds != 0 && $urandom_range(1, send_odds) == 1) ? $urandom_range(1, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_words++;
   endtask

   task automatic pulls(int n);
      repeat (n) send_word(KIND_PULL, 8'($urandom));
   endtask

   // Stop sending and let every outstanding word come back before touching registers.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Upper data bits are random; only the low three select the protocol.
   function automatic logic [7:0] pick_protocol();
      logic [PROT_W-1:0] p;
      if ($urandom_range(0, 11) == 0) p = $urandom_range(0, 1) ? PROTO_NONE_B : PROTO_NONE_A;
      else p = PROT_W'($urandom_range(PROTO_NEC, PROTO_ITT));
      return {5'($urandom), p};
   endfunction

   function automatic logic [7:0] pick_address();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic write_random_reg();
      if ($urandom_range(0, 1)) write_csr(CSR_PROTOCOL, pick_protocol());
      else write_csr(CSR_ADDRESS, pick_address());
   endtask

   task automatic pick_idling();
      if (sent_words >= TOTAL_WORDS - QUIET_TAIL) begin
         send_odds = 0;
         rsp_odds  = 0;
      end else begin
         send_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         rsp_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      end
   endtask

   initial begin
      int frames;
      int len;
      int mode;
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting from the reset configuration.
      send_odds = 3;
      rsp_odds  = 3;
      pulls(1);                               // pull with no frame pending
      send_word(KIND_PRESS, 8'hFF);
      pulls(3);
      drain();
      write_csr(CSR_ADDRESS, 8'hFF);          // must not disturb the running frame
      midframe_writes++;
      pulls(2);
      send_word(KIND_PRESS, 8'h00);           // drops the frame and restarts
      pulls(2);
      drain();
      write_csr(CSR_PROTOCOL, {5'b11111, PROTO_NONE_A});
      send_word(KIND_PRESS, 8'h5A);
      pulls(1);
      drain();
      write_csr(CSR_PROTOCOL, {5'b00000, PROTO_NONE_B});
      send_word(KIND_PRESS, 8'hA5);
      pulls(1);
      drain();
      write_csr(CSR_ADDRESS, 8'h00);
      write_csr(CSR_PROTOCOL, {5'b00000, PROTO_NEC});
      send_word(KIND_PRESS, 8'hA5);
      pulls(2);

      while (sent_words < TOTAL_WORDS) begin
         drain();
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_PROTOCOL, pick_protocol());
            write_csr(CSR_ADDRESS, pick_address());
         end else begin
            write_csr(CSR_ADDRESS, pick_address());
            write_csr(CSR_PROTOCOL, pick_protocol());
         end
         pick_idling();
         frames = $urandom_range(1, 3);
         repeat (frames) begin
            send_word(KIND_PRESS, 8'($urandom));
            len  = sb.pulses_in_frame(sb.protocol_reg);
            mode = $urandom_range(0, 9);
            if (len == 0) begin
               pulls($urandom_range(0, 2));
            end else if (mode <= 6) begin
               pulls(len + $urandom_range(0, 2));
            end else if (mode == 7) begin
               pulls($urandom_range(0, len));  // cut short by the next press
            end else if (mode == 8) begin
               k = $urandom_range(1, len - 1);
               pulls(k);
               drain();
               write_random_reg();
               midframe_writes++;
               pulls(len - k + $urandom_range(0, 1));
            end else begin
               repeat ($urandom_range(1, 8))
                  send_word($urandom_range(0, 3) == 0 ? KIND_PRESS : KIND_PULL, 8'($urandom));
            end
         end
      end

      req_tvalid <= 1'b0;
      send_odds = 0;
      rsp_odds  = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.pending() != 0) $display("%0d expected words never arrived", sb.pending());
      $display("Sent %0d words with %0d presses; checked %0d results (%0d empty, %0d ends).",
               sent_words, sb.presses, sb.words_checked, sb.empty_words, sb.frame_ends);
      $display({"Protocols started (bit per code): %b; register writes inside a frame: %0d; ",
                "mismatches: %0d."}, sb.proto_seen, midframe_writes, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> ir_remote_pulse_frame_generator_core.f
rtl/irpfg_pkg.sv
rtl/ir_remote_pulse_frame_generator_core.sv
test/tb_ir_remote_pulse_frame_generator_core.sv
